>>> rtl/core/pdrf_pkg.sv
package pdrf_pkg;

  // Frame layout and protocol constants.
  localparam int MAX_PAYLOAD = 1494;
  localparam int UNIQ_BYTES  = 4;
  localparam int UNIQ_W      = 8 * UNIQ_BYTES;
  localparam int UNIQ_IDX_W  = (UNIQ_BYTES > 1) ? $clog2(UNIQ_BYTES) : 1;

  localparam int MAC_BYTES   = 6;
  localparam int MAC_IDX_W   = $clog2(MAC_BYTES);
  localparam int POS_W       = 11;
  localparam int PHASE_W     = 11;
  localparam int OFF_W       = 11;

  localparam logic [POS_W-1:0] POS_MAX      = '1;
  localparam logic [POS_W-1:0] POS_VER_TYPE = POS_W'(14);
  localparam logic [POS_W-1:0] POS_CODE     = POS_W'(15);
  localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(18);
  localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(19);
  localparam logic [POS_W-1:0] POS_TAGS     = POS_W'(20);

  localparam int HDR_BYTES = 20;
  localparam int TAG_HDR   = 4;

  localparam logic [15:0] HOST_UNIQ_TYPE = 16'h0103;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_MAC   = 2'd0,
    CFG_USE_UNIQ  = 2'd1,
    CFG_HOST_UNIQ = 2'd2
  } cfg_idx_t;

  // Parse status reported with each frame.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_VER   = 3'd1,
    ST_BAD_TYPE  = 3'd2,
    ST_LEN_LARGE = 3'd3,
    ST_BAD_TAG   = 3'd4,
    ST_SHORT     = 3'd5
  } status_t;

endpackage

>>> rtl/core/pdrf_in_if.sv
interface pdrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last;

  modport source (output valid, frame_byte, last, input ready);
  modport sink   (input valid, frame_byte, last, output ready);
endinterface

>>> rtl/core/pdrf_out_if.sv
interface pdrf_out_if;
  logic       valid;
  logic       ready;
  logic       for_me;
  logic [2:0] status;
  logic [7:0] pppoe_code;

  modport source (output valid, for_me, status, pppoe_code, input ready);
  modport sink   (input valid, for_me, status, pppoe_code, output ready);
endinterface

>>> rtl/core/pppoe_discovery_receive_filter.sv
// Channel   Dir  Beat contents                      Handshake
// in_ch     in   frame_byte[7:0], last              valid/ready
// out_ch    out  for_me, status[2:0], pppoe_code    valid/ready
// cfg_*     in   cfg_index[1:0], cfg_wdata[47:0]    cfg_we, no back-pressure
//
// One byte is taken every cycle unless a final byte is held; each byte waits in the
// input register and is then applied to the frame state, and a frame's result is
// registered in the result register when its last byte leaves the input register.
// Reset is synchronous and active low; it clears the configuration and frame state.
// A stalled result holds only the last byte of the next frame; other bytes flow on.
module pppoe_discovery_receive_filter import pdrf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  pdrf_in_if.sink               in_ch,
  pdrf_out_if.source            out_ch
);

  // Configuration registers.
  logic [47:0] own_mac_r;
  logic        use_uniq_r;
  logic [31:0] host_uniq_r;

  // Input register.
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  // Frame state.
  logic [POS_W-1:0]   byte_pos_r,   byte_pos_nxt;
  logic               dest_match_r, dest_match_nxt;
  logic [7:0]         code_r,       code_nxt;
  logic [15:0]        plen_r,       plen_nxt;
  logic [OFF_W-1:0]   tag_off_r,    tag_off_nxt;
  logic [15:0]        tag_type_r,   tag_type_nxt;
  logic [15:0]        tag_len_r,    tag_len_nxt;
  logic [PHASE_W-1:0] phase_r,      phase_nxt;
  logic               cmp_ok_r,     cmp_ok_nxt;
  logic               seen_r,       seen_nxt;
  logic               walk_done_r,  walk_done_nxt;
  status_t            pstat_r,      pstat_nxt;

  // Result register.
  logic    out_valid_r;
  logic    for_me_r,  for_me_nxt;
  status_t status_r,  status_nxt;
  logic [7:0] pcode_r;

  logic out_free;
  logic s1_adv;
  logic in_acc;
  logic frame_end;

  logic [7:0] mac_bytes  [MAC_BYTES];
  logic [7:0] uniq_bytes [UNIQ_BYTES];
  logic [UNIQ_W-1:0] uniq_full;

  // Handshake: a byte leaves the input register unless it ends a frame
  // whose result cannot yet be placed.
  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign frame_end = s1_adv && s1_last_r;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc    = in_ch.valid && in_ch.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r   <= '0;
      use_uniq_r  <= 1'b0;
      host_uniq_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_MAC:   own_mac_r   <= cfg_wdata[47:0];
        CFG_USE_UNIQ:  use_uniq_r  <= cfg_wdata[0];
        CFG_HOST_UNIQ: host_uniq_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Expected bytes in wire order.
  assign uniq_full = UNIQ_W'(host_uniq_r);
  always_comb begin
    for (int i = 0; i < MAC_BYTES; i++) begin
      mac_bytes[i] = own_mac_r[8*(MAC_BYTES-1-i) +: 8];
    end
    for (int j = 0; j < UNIQ_BYTES; j++) begin
      uniq_bytes[j] = uniq_full[8*(UNIQ_BYTES-1-j) +: 8];
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.frame_byte;
      s1_last_r <= in_ch.last;
    end
  end

  // Frame state update for the byte in the input register.
  always_comb begin
    logic [7:0]         b;
    logic [15:0]        tlen;
    logic [16:0]        tag_end;
    logic               do_finish;
    logic               uniq_cur;
    logic               uniq_fin;
    logic [UNIQ_IDX_W-1:0] uidx;
    logic [11:0]        frame_len;
    logic [16:0]        need_len;
    logic               short_frame;

    b         = s1_byte_r;
    do_finish = 1'b0;
    tlen      = '0;
    tag_end   = '0;
    uniq_cur  = (tag_type_r == HOST_UNIQ_TYPE) && (tag_len_r == 16'(UNIQ_BYTES));
    uidx      = UNIQ_IDX_W'(phase_r - PHASE_W'(TAG_HDR));

    byte_pos_nxt   = byte_pos_r;
    dest_match_nxt = dest_match_r;
    code_nxt       = code_r;
    plen_nxt       = plen_r;
    tag_off_nxt    = tag_off_r;
    tag_type_nxt   = tag_type_r;
    tag_len_nxt    = tag_len_r;
    phase_nxt      = phase_r;
    cmp_ok_nxt     = cmp_ok_r;
    seen_nxt       = seen_r;
    walk_done_nxt  = walk_done_r;
    pstat_nxt      = pstat_r;

    // Ethernet and PPPoE header fields.
    if (byte_pos_r < POS_W'(MAC_BYTES)) begin
      if (b != mac_bytes[byte_pos_r[MAC_IDX_W-1:0]]) begin
        dest_match_nxt = 1'b0;
      end
    end else if (byte_pos_r == POS_VER_TYPE) begin
      tag_type_nxt = {8'h00, b};
    end else if (byte_pos_r == POS_CODE) begin
      code_nxt = b;
    end else if (byte_pos_r == POS_LEN_HI) begin
      plen_nxt = {b, 8'h00};
    end else if (byte_pos_r == POS_LEN_LO) begin
      plen_nxt      = {plen_r[15:8], b};
      tag_type_nxt  = '0;
      walk_done_nxt = 1'b1;
      if (tag_type_r[7:4] != 4'd1) begin
        pstat_nxt = ST_BAD_VER;
      end else if (tag_type_r[3:0] != 4'd1) begin
        pstat_nxt = ST_BAD_TYPE;
      end else if (plen_nxt > 16'(MAX_PAYLOAD)) begin
        pstat_nxt = ST_LEN_LARGE;
      end else if (plen_nxt != 16'd0) begin
        walk_done_nxt = 1'b0;
      end
    end else if (byte_pos_r >= POS_TAGS && !walk_done_r) begin
      // Tag walk: four header bytes, then the tag value.
      if (phase_r < PHASE_W'(TAG_HDR)) begin
        phase_nxt = phase_r + 1'b1;
        unique case (phase_r[1:0])
          2'd0: tag_type_nxt = {b, 8'h00};
          2'd1: tag_type_nxt = {tag_type_r[15:8], b};
          2'd2: tag_len_nxt  = {b, 8'h00};
          2'd3: begin
            tlen        = {tag_len_r[15:8], b};
            tag_len_nxt = tlen;
            tag_end     = 17'(tag_off_r) + 17'(tlen) + 17'(TAG_HDR);
            if (tag_type_r == 16'd0) begin
              walk_done_nxt = 1'b1;
            end else if (tag_end > 17'(plen_r)) begin
              pstat_nxt     = ST_BAD_TAG;
              walk_done_nxt = 1'b1;
            end else begin
              cmp_ok_nxt = 1'b1;
              do_finish  = (tlen == 16'd0);
            end
          end
          default: ;
        endcase
      end else begin
        if (uniq_cur && b != uniq_bytes[uidx]) begin
          cmp_ok_nxt = 1'b0;
        end
        phase_nxt = phase_r + 1'b1;
        do_finish = (17'(phase_nxt) == 17'(tag_len_r) + 17'(TAG_HDR));
      end
    end

    // Tag complete: record a Host-Uniq match and move to the next tag.
    uniq_fin = (tag_type_nxt == HOST_UNIQ_TYPE) && (tag_len_nxt == 16'(UNIQ_BYTES));
    if (do_finish) begin
      if (uniq_fin && cmp_ok_nxt) begin
        seen_nxt = 1'b1;
      end
      tag_off_nxt = tag_off_r + OFF_W'(TAG_HDR) + tag_len_nxt[OFF_W-1:0];
      phase_nxt   = '0;
      cmp_ok_nxt  = 1'b1;
      if (16'(tag_off_nxt) >= plen_nxt) begin
        walk_done_nxt = 1'b1;
      end
    end

    if (byte_pos_r != POS_MAX) begin
      byte_pos_nxt = byte_pos_r + 1'b1;
    end

    // Result for a frame that ends on this byte.
    frame_len   = 12'(byte_pos_r) + 12'd1;
    need_len    = 17'(HDR_BYTES) + 17'(plen_nxt);
    short_frame = 17'(frame_len) < need_len;
    if (short_frame) begin
      status_nxt = ST_SHORT;
      for_me_nxt = 1'b0;
    end else begin
      status_nxt = walk_done_nxt ? pstat_nxt : ST_BAD_TAG;
      for_me_nxt = dest_match_nxt && (!use_uniq_r || seen_nxt);
    end
  end

  // Frame state registers; cleared at reset and after each frame.
  always_ff @(posedge clk) begin
    if (!rst_n || frame_end) begin
      byte_pos_r   <= '0;
      dest_match_r <= 1'b1;
      code_r       <= '0;
      plen_r       <= '0;
      tag_off_r    <= '0;
      tag_type_r   <= '0;
      tag_len_r    <= '0;
      phase_r      <= '0;
      cmp_ok_r     <= 1'b1;
      seen_r       <= 1'b0;
      walk_done_r  <= 1'b0;
      pstat_r      <= ST_OK;
    end else if (s1_adv) begin
      byte_pos_r   <= byte_pos_nxt;
      dest_match_r <= dest_match_nxt;
      code_r       <= code_nxt;
      plen_r       <= plen_nxt;
      tag_off_r    <= tag_off_nxt;
      tag_type_r   <= tag_type_nxt;
      tag_len_r    <= tag_len_nxt;
      phase_r      <= phase_nxt;
      cmp_ok_r     <= cmp_ok_nxt;
      seen_r       <= seen_nxt;
      walk_done_r  <= walk_done_nxt;
      pstat_r      <= pstat_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      for_me_r <= for_me_nxt;
      status_r <= status_nxt;
      pcode_r  <= code_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.for_me     = for_me_r;
  assign out_ch.status     = status_r;
  assign out_ch.pppoe_code = pcode_r;

  // A short frame is never reported as addressed to this station.
  a_short_not_me: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_SHORT) |-> !for_me_r)
    else $error("short frame reported with for_me set");

  // Any error status stops the tag walk.
  a_err_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (pstat_r != ST_OK) |-> walk_done_r)
    else $error("error status recorded while tag walk still running");

  // The byte counter restarts after every frame.
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> (byte_pos_r == '0))
    else $error("byte position not cleared at frame end");

  // Within a frame the byte counter steps by one until it saturates.
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_last_r && byte_pos_r != POS_MAX)
      |=> (byte_pos_r == $past(byte_pos_r) + 1'b1))
    else $error("byte position did not advance");

  // Input back-pressure only while a byte is held.
  a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_last_r && !out_free))
    else $error("input stalled without a held final byte");

endmodule
